FILE: src/cron_schedule_matcher_unit_assert.svh
// Assertion macros for the cron schedule matcher top level.
`ifndef CRON_SCHEDULE_MATCHER_UNIT_ASSERT_SVH
`define CRON_SCHEDULE_MATCHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cron schedule matcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cron schedule matcher check failed");

`endif

FILE: src/csm_pkg.sv
// Shared types and constants for the cron schedule matcher.
package csm_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int IDX_W       = 4;
    localparam int MASK_W      = 16;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_TICK  = 1'b1
    } t_req;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
    } t_time;

    typedef struct packed {
        logic minute;
        logic hour;
        logic day;
        logic month;
        logic year;
    } t_any;

    typedef struct packed {
        logic              vld;
        t_time             now;
        logic [MASK_W-1:0] mask;
    } t_word;

endpackage

FILE: src/csm_cell.sv
// One schedule entry cell: holds the entry, matches a passing tick word and forwards it.
module csm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  csm_pkg::t_time i_pat_val,
    input  csm_pkg::t_any  i_pat_any,
    input  csm_pkg::t_word i_word,
    output csm_pkg::t_word o_word
);

    csm_pkg::t_time r_pat_val;
    csm_pkg::t_any  r_pat_any;
    logic           r_valid;
    logic           n_valid;
    csm_pkg::t_time r_last;
    csm_pkg::t_time n_last;
    csm_pkg::t_word r_word;
    csm_pkg::t_word n_word;

    logic w_match;
    logic w_differs;
    logic w_fire;
    logic [csm_pkg::MASK_W-1:0] w_bit;

    always_comb begin
        w_match = (r_pat_any.minute || (r_pat_val.minute == i_word.now.minute))
               && (r_pat_any.hour   || (r_pat_val.hour   == i_word.now.hour))
               && (r_pat_any.day    || (r_pat_val.day    == i_word.now.day))
               && (r_pat_any.month  || (r_pat_val.month  == i_word.now.month))
               && (r_pat_any.year   || (r_pat_val.year   == i_word.now.year));
        w_differs = (r_pat_any.minute && (r_last.minute != i_word.now.minute))
                 || (r_pat_any.hour   && (r_last.hour   != i_word.now.hour))
                 || (r_pat_any.day    && (r_last.day    != i_word.now.day))
                 || (r_pat_any.month  && (r_last.month  != i_word.now.month))
                 || (r_pat_any.year   && (r_last.year   != i_word.now.year));
        w_fire = i_word.vld && r_valid && w_match && w_differs;
        w_bit  = csm_pkg::MASK_W'(w_fire) << CELL_INDEX;
    end

    always_comb begin
        n_valid = r_valid || i_wr_en;
        if (i_wr_en) begin
            n_last = '1;
        end else if (w_fire) begin
            n_last = i_word.now;
        end else begin
            n_last = r_last;
        end
        n_word      = i_word;
        n_word.mask = i_word.mask | w_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_last     <= '1;
            r_word.vld <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_last     <= n_last;
            r_word.vld <= n_word.vld;
        end
        if (i_wr_en) begin
            r_pat_val <= i_pat_val;
            r_pat_any <= i_pat_any;
        end
        r_word.now  <= n_word.now;
        r_word.mask <= n_word.mask;
    end

    assign o_word = r_word;

endmodule

FILE: src/cron_schedule_matcher_unit.sv
// Cron schedule matcher top level: a chain of entry cells, input control and output register.
// A write word loads one entry and yields a zero mask word in the cycle after it is taken; a
// write to a slot at or above ENTRIES only yields that zero word. A tick word enters the
// chain of ENTRIES cells and moves one cell per cycle; its fire mask passes through every
// cell register and then the output register, and no new word is taken while a tick is in
// the chain. Entries 16 and up cannot be addressed by the 4-bit index and do not show in
// the mask. The output register holds a finished word while the receiver stalls it.
`include "cron_schedule_matcher_unit_assert.svh"

module cron_schedule_matcher_unit #(
    parameter int ENTRIES = csm_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [csm_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [5:0]                 i_minute_value,
    input  logic [4:0]                 i_hour_value,
    input  logic [4:0]                 i_day_value,
    input  logic [3:0]                 i_month_value,
    input  logic [7:0]                 i_year_value,
    input  logic                       i_minute_any,
    input  logic                       i_hour_any,
    input  logic                       i_day_any,
    input  logic                       i_month_any,
    input  logic                       i_year_any,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [csm_pkg::MASK_W-1:0] o_fire_mask
);

    csm_pkg::t_word w_chain [0:ENTRIES];
    csm_pkg::t_time w_time;
    csm_pkg::t_any  w_any;
    logic [ENTRIES-1:0] w_wr_en;

    logic w_in_accept;
    logic w_wr_accept;
    logic w_tick_accept;
    logic w_out_free;

    logic r_busy;
    logic n_busy;
    logic r_out_valid;
    logic n_out_valid;
    logic [csm_pkg::MASK_W-1:0] r_out_mask;
    logic [csm_pkg::MASK_W-1:0] n_out_mask;

    always_comb begin
        w_time.minute = i_minute_value;
        w_time.hour   = i_hour_value;
        w_time.day    = i_day_value;
        w_time.month  = i_month_value;
        w_time.year   = i_year_value;
        w_any.minute  = i_minute_any;
        w_any.hour    = i_hour_any;
        w_any.day     = i_day_any;
        w_any.month   = i_month_any;
        w_any.year    = i_year_any;
    end

    assign w_out_free    = !r_out_valid || !i_stall;
    assign o_stall       = r_busy || !w_out_free;
    assign w_in_accept   = i_valid && !o_stall;
    assign w_wr_accept   = w_in_accept && (i_req_type == csm_pkg::REQ_WRITE);
    assign w_tick_accept = w_in_accept && (i_req_type == csm_pkg::REQ_TICK);

    assign w_chain[0] = {w_tick_accept, w_time, csm_pkg::MASK_W'(0)};

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        assign w_wr_en[k] = w_wr_accept && (32'(i_entry_index) == 32'(k));

        csm_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wr_en[k]),
            .i_pat_val (w_time),
            .i_pat_any (w_any),
            .i_word    (w_chain[k]),
            .o_word    (w_chain[k+1])
        );
    end

    always_comb begin
        n_busy      = (r_busy && !w_chain[ENTRIES].vld) || w_tick_accept;
        n_out_valid = w_chain[ENTRIES].vld || w_wr_accept || (r_out_valid && i_stall);
        if (w_chain[ENTRIES].vld) begin
            n_out_mask = w_chain[ENTRIES].mask;
        end else if (w_wr_accept) begin
            n_out_mask = '0;
        end else begin
            n_out_mask = r_out_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_mask <= n_out_mask;
    end

    assign o_valid     = r_out_valid;
    assign o_fire_mask = r_out_mask;

    `CSM_ASSERT_NEXT(a_tick_sets_busy, i_clk, i_rst_n, w_tick_accept, r_busy)
    `CSM_ASSERT_SAME(a_tail_into_free_out, i_clk, i_rst_n, w_chain[ENTRIES].vld, !r_out_valid)
    `CSM_ASSERT_NEXT(a_write_gives_zero, i_clk, i_rst_n, w_wr_accept, r_out_valid && (r_out_mask == '0))
    `CSM_ASSERT_NEXT(a_busy_holds, i_clk, i_rst_n, r_busy && !w_chain[ENTRIES].vld, r_busy)

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the cron schedule matcher with its own entry table model.
`timescale 1ns / 1ps

module testbench;
    import csm_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int RUN_LIMIT    = 400000;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_FROM   = 1000;
    localparam int QUIET_TO     = 1350;

    typedef struct packed {
        t_req              kind;
        logic [IDX_W-1:0]  idx;
        t_time             tm;
        t_any              any;
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic              has_exp;
        logic [MASK_W-1:0] mask;
    } t_dir_row;

    typedef struct {
        logic              has_exp;
        logic [MASK_W-1:0] mask;
    } t_note;

    localparam t_time T_ZERO = '0;
    localparam t_time T_ONES = '1;
    localparam t_time T_MID  = '{6'd10, 5'd12, 5'd5, 4'd3, 8'd124};
    localparam t_time T_SLOT = '{6'd30, 5'd8, 5'd1, 4'd0, 8'd100};

    localparam int NUM_DIR = 24;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{'{REQ_TICK,  4'd0,  T_ZERO, 5'b00000}, 1'b1, 16'h0000},
        '{'{REQ_WRITE, 4'd0,  T_ZERO, 5'b11111}, 1'b1, 16'h0000},
        '{'{REQ_TICK,  4'hF,  T_ONES, 5'b11111}, 1'b1, 16'h0000},
        '{'{REQ_TICK,  4'd0,  T_ZERO, 5'b00000}, 1'b1, 16'h0001},
        '{'{REQ_TICK,  4'd0,  T_ZERO, 5'b00000}, 1'b1, 16'h0000},
        '{'{REQ_WRITE, 4'd15, T_ONES, 5'b00000}, 1'b1, 16'h0000},
        '{'{REQ_TICK,  4'd0,  T_ONES, 5'b00000}, 1'b1, 16'h0001},
        '{'{REQ_WRITE, 4'd7,  '{6'd0, 5'd12, 5'd5, 4'd3, 8'd124}, 5'b10000}, 1'b1, 16'h0000},
        '{'{REQ_TICK,  4'd0,  '{6'd63, 5'd12, 5'd5, 4'd3, 8'd124}, 5'b00000}, 1'b1, 16'h0001},
        '{'{REQ_TICK,  4'd0,  T_MID, 5'b00000}, 1'b0, 16'h0000},
        '{'{REQ_TICK,  4'd0,  T_MID, 5'b00000}, 1'b0, 16'h0000},
        '{'{REQ_TICK,  4'd0,  '{6'd10, 5'd13, 5'd5, 4'd3, 8'd124}, 5'b00000}, 1'b0, 16'h0000},
        '{'{REQ_WRITE, 4'd3,  '{6'd30, 5'd0, 5'd1, 4'd0, 8'd100}, 5'b01000}, 1'b1, 16'h0000},
        '{'{REQ_WRITE, 4'd4,  '{6'd30, 5'd8, 5'd0, 4'd0, 8'd100}, 5'b00100}, 1'b1, 16'h0000},
        '{'{REQ_WRITE, 4'd5,  '{6'd30, 5'd8, 5'd1, 4'd0, 8'd100}, 5'b00010}, 1'b1, 16'h0000},
        '{'{REQ_WRITE, 4'd6,  '{6'd30, 5'd8, 5'd1, 4'd0, 8'd0}, 5'b00001}, 1'b1, 16'h0000},
        '{'{REQ_TICK,  4'd0,  T_SLOT, 5'b00000}, 1'b0, 16'h0000},
        '{'{REQ_TICK,  4'd0,  T_SLOT, 5'b00000}, 1'b0, 16'h0000},
        '{'{REQ_WRITE, 4'd3,  '{6'd30, 5'd0, 5'd1, 4'd0, 8'd100}, 5'b01000}, 1'b1, 16'h0000},
        '{'{REQ_TICK,  4'd0,  T_SLOT, 5'b00000}, 1'b0, 16'h0000},
        '{'{REQ_WRITE, 4'd9,  '{6'd5, 5'd5, 5'd5, 4'd5, 8'd5}, 5'b00000}, 1'b1, 16'h0000},
        '{'{REQ_TICK,  4'd0,  '{6'd5, 5'd5, 5'd5, 4'd5, 8'd5}, 5'b00000}, 1'b0, 16'h0000},
        '{'{REQ_TICK,  4'hA,  T_ZERO, 5'b10101}, 1'b0, 16'h0000},
        '{'{REQ_WRITE, 4'd0,  T_ZERO, 5'b00000}, 1'b1, 16'h0000}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_req_type = 1'b0;
    logic [IDX_W-1:0]  i_entry_index = '0;
    logic [5:0]        i_minute_value = '0;
    logic [4:0]        i_hour_value = '0;
    logic [4:0]        i_day_value = '0;
    logic [3:0]        i_month_value = '0;
    logic [7:0]        i_year_value = '0;
    logic              i_minute_any = 1'b0;
    logic              i_hour_any = 1'b0;
    logic              i_day_any = 1'b0;
    logic              i_month_any = 1'b0;
    logic              i_year_any = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [MASK_W-1:0] o_fire_mask;

    cron_schedule_matcher_unit dut (.*);

    // Model of the entry table, advanced as words are taken.
    bit                 ent_ok   [ENTRIES_DEF];
    t_time              ent_pat  [ENTRIES_DEF];
    t_any               ent_any  [ENTRIES_DEF];
    t_time              ent_last [ENTRIES_DEF];

    // Copy of the table as the stimulus side has written it, used to aim ticks.
    bit                 plan_ok  [ENTRIES_DEF];
    t_time              plan_pat [ENTRIES_DEF];
    t_any               plan_any [ENTRIES_DEF];
    t_time              plan_prev = '0;

    logic [MASK_W-1:0]  fire_q[$];
    t_note              note_q[$];
    int                 taken_cnt = 0;
    int                 err_cnt = 0;
    int                 cycle_cnt = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                   input logic [MASK_W-1:0] want);
        err_cnt++;
        if (err_cnt <= 50) begin
            $display("mismatch: %s, got %h, expected %h, cycle %0d", what, got, want, cycle_cnt);
        end
    endtask

    function automatic void match_field(input logic wild, input logic [7:0] pat,
                                        input logic [7:0] last, input logic [7:0] now,
                                        inout bit hit, inout bit diff);
        if (wild) begin
            if (last != now) diff = 1'b1;
        end else if (pat != now) begin
            hit = 1'b0;
        end
    endfunction

    function automatic logic [MASK_W-1:0] predict_fire(input t_cmd c);
        logic [MASK_W-1:0] mask;
        bit hit;
        bit diff;
        mask = '0;
        if (c.kind == REQ_WRITE) begin
            ent_ok[c.idx]   = 1'b1;
            ent_pat[c.idx]  = c.tm;
            ent_any[c.idx]  = c.any;
            ent_last[c.idx] = '1;
            return mask;
        end
        for (int e = 0; e < ENTRIES_DEF; e++) begin
            if (ent_ok[e]) begin
                hit  = 1'b1;
                diff = 1'b0;
                match_field(ent_any[e].minute, 8'(ent_pat[e].minute), 8'(ent_last[e].minute),
                            8'(c.tm.minute), hit, diff);
                match_field(ent_any[e].hour, 8'(ent_pat[e].hour), 8'(ent_last[e].hour),
                            8'(c.tm.hour), hit, diff);
                match_field(ent_any[e].day, 8'(ent_pat[e].day), 8'(ent_last[e].day),
                            8'(c.tm.day), hit, diff);
                match_field(ent_any[e].month, 8'(ent_pat[e].month), 8'(ent_last[e].month),
                            8'(c.tm.month), hit, diff);
                match_field(ent_any[e].year, ent_pat[e].year, ent_last[e].year,
                            c.tm.year, hit, diff);
                if (hit && diff) begin
                    ent_last[e] = c.tm;
                    if (e < MASK_W) mask[e] = 1'b1;
                end
            end
        end
        return mask;
    endfunction

    function automatic logic [7:0] pick_field(input logic wild, input logic [7:0] pat,
                                              input logic [7:0] prev, input int unsigned w);
        logic [7:0] ones;
        int unsigned r;
        ones = 8'((1 << w) - 1);
        if (!wild) return pat;
        r = $urandom_range(5);
        if (r < 2) return prev;
        if (r == 5) return ones;
        return 8'($urandom) & ones;
    endfunction

    // Most ticks are aimed at a written entry so that its fixed fields match.
    function automatic t_cmd make_word();
        t_cmd c;
        int unsigned r;
        int unsigned e;
        c.idx = IDX_W'($urandom);
        c.tm  = t_time'($urandom);
        c.any = t_any'($urandom);
        r = $urandom_range(99);
        if (r < 22) begin
            c.kind = REQ_WRITE;
            if ($urandom_range(9) == 0) c.any = '0;
            return c;
        end
        c.kind = REQ_TICK;
        if (r < 30) return c;
        if (r < 42) begin
            c.tm = plan_prev;
            return c;
        end
        e = $urandom_range(ENTRIES_DEF - 1);
        if (!plan_ok[e]) return c;
        c.tm.minute = 6'(pick_field(plan_any[e].minute, 8'(plan_pat[e].minute),
                                    8'(plan_prev.minute), 6));
        c.tm.hour   = 5'(pick_field(plan_any[e].hour, 8'(plan_pat[e].hour),
                                    8'(plan_prev.hour), 5));
        c.tm.day    = 5'(pick_field(plan_any[e].day, 8'(plan_pat[e].day),
                                    8'(plan_prev.day), 5));
        c.tm.month  = 4'(pick_field(plan_any[e].month, 8'(plan_pat[e].month),
                                    8'(plan_prev.month), 4));
        c.tm.year   = pick_field(plan_any[e].year, plan_pat[e].year, plan_prev.year, 8);
        return c;
    endfunction

    function automatic bit quiet_stretch();
        return taken_cnt >= QUIET_FROM && taken_cnt < QUIET_TO;
    endfunction

    task automatic send_word(input t_cmd c, input logic has_exp, input logic [MASK_W-1:0] mask);
        t_note n;
        if (c.kind == REQ_WRITE) begin
            plan_ok[c.idx]  = 1'b1;
            plan_pat[c.idx] = c.tm;
            plan_any[c.idx] = c.any;
        end else begin
            plan_prev = c.tm;
        end
        while (!quiet_stretch() && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        n.has_exp = has_exp;
        n.mask    = mask;
        note_q.push_back(n);
        i_valid        <= 1'b1;
        i_req_type     <= c.kind;
        i_entry_index  <= c.idx;
        i_minute_value <= c.tm.minute;
        i_hour_value   <= c.tm.hour;
        i_day_value    <= c.tm.day;
        i_month_value  <= c.tm.month;
        i_year_value   <= c.tm.year;
        i_minute_any   <= c.any.minute;
        i_hour_any     <= c.any.hour;
        i_day_any      <= c.any.day;
        i_month_any    <= c.any.month;
        i_year_any     <= c.any.year;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : watch
        t_cmd c;
        t_note n;
        logic [MASK_W-1:0] want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                c.kind = t_req'(i_req_type);
                c.idx  = i_entry_index;
                c.tm   = '{i_minute_value, i_hour_value, i_day_value, i_month_value,
                           i_year_value};
                c.any  = '{i_minute_any, i_hour_any, i_day_any, i_month_any, i_year_any};
                want = predict_fire(c);
                n = note_q.pop_front();
                fire_q.push_back(n.has_exp ? n.mask : want);
                taken_cnt <= taken_cnt + 1;
            end
            if (o_valid && !i_stall) begin
                if (fire_q.size() == 0) begin
                    report_mismatch("result word with none pending", o_fire_mask, '0);
                end else begin
                    want = fire_q.pop_front();
                    if (o_fire_mask !== want) report_mismatch("fire_mask", o_fire_mask, want);
                end
            end
        end
    end

    initial begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && taken_cnt >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet_stretch() && ($urandom_range(99) < 17);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        for (int e = 0; e < ENTRIES_DEF; e++) begin
            ent_ok[e]   = 1'b0;
            ent_pat[e]  = '0;
            ent_any[e]  = '0;
            ent_last[e] = '1;
            plan_ok[e]  = 1'b0;
            plan_pat[e] = '0;
            plan_any[e] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < NUM_DIR; i++) begin
            send_word(DIR_ROWS[i].cmd, DIR_ROWS[i].has_exp, DIR_ROWS[i].mask);
        end
        repeat (RANDOM_ITEMS) send_word(make_word(), 1'b0, '0);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (fire_q.size() != 0) @(posedge i_clk);
        repeat (2 * ENTRIES_DEF + 8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/csm_pkg.sv
src/csm_cell.sv
src/cron_schedule_matcher_unit.sv
test/testbench.sv
